// File: rtl/lsod_pkg.sv
// Shared constants, codes and types for the lidar sector obstacle detector.
`default_nettype none
package lsod_pkg;

   localparam int MAX_SAMPLES = 1024;
   localparam int IDX_W       = $clog2(MAX_SAMPLES) + 1;
   localparam int RANGE_W     = 16;
   localparam int END_W       = 10;
   localparam int NUM_SECTORS = 6;
   localparam int ACTION_W    = 3;
   localparam int CSR_IDX_W   = 3;

   localparam logic [RANGE_W-1:0] NO_RETURN = '1;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REAR_RIGHT_END  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_END       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_RIGHT_END = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT_LEFT_END  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_END        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REAR_LEFT_END   = 3'd6;

   // sector positions in the detect mask
   localparam int SEC_REAR_RIGHT  = 0;
   localparam int SEC_RIGHT       = 1;
   localparam int SEC_FRONT_RIGHT = 2;
   localparam int SEC_FRONT_LEFT  = 3;
   localparam int SEC_LEFT        = 4;
   localparam int SEC_REAR_LEFT   = 5;

   // steering actions
   localparam logic [ACTION_W-1:0] ACT_BOTH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TURN_RIGHT = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_TURN_LEFT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_VEER_RIGHT = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_VEER_LEFT  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_REAR_RIGHT = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_REAR_LEFT  = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_FORWARD    = 3'd7;

   // one sample beat as it leaves the input register
   typedef struct packed {
      logic               fire;
      logic               last;
      logic [IDX_W-1:0]   index;
      logic [RANGE_W-1:0] range_mm;
   } lsod_samp_type;

endpackage
`default_nettype wire

// File: rtl/lidar_sector_obstacle_detect.sv
// Top level: sample input register, six sector units, steering decision and result register.
// A last sample's result passes the input register and then the result register before it shows
// on rsp_. Throughput: one sample per cycle while req_stall is low.
// The input register holds while a finished result waits and the next one is due.
// Reset: synchronous; the threshold and sector ends return to their defaults, minima to
// no-return, the sample index to zero, and both stages empty.
`default_nettype none
module lidar_sector_obstacle_detect (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [lsod_pkg::RANGE_W-1:0]    req_range_mm,
   input  wire logic                            req_last_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [lsod_pkg::ACTION_W-1:0]   rsp_action,
   output logic      [lsod_pkg::NUM_SECTORS-1:0] rsp_detect_mask,
   output logic      [lsod_pkg::RANGE_W-1:0]    rsp_min_rear_right,
   output logic      [lsod_pkg::RANGE_W-1:0]    rsp_min_right,
   output logic      [lsod_pkg::RANGE_W-1:0]    rsp_min_front_right,
   output logic      [lsod_pkg::RANGE_W-1:0]    rsp_min_front_left,
   output logic      [lsod_pkg::RANGE_W-1:0]    rsp_min_left,
   output logic      [lsod_pkg::RANGE_W-1:0]    rsp_min_rear_left,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lsod_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lsod_pkg::RANGE_W-1:0]    csr_wdata
);

   // configuration
   logic [lsod_pkg::RANGE_W-1:0] threshold_ff;
   logic [lsod_pkg::END_W-1:0]   end_ff [lsod_pkg::NUM_SECTORS];

   // input stage
   logic                         s1_valid_ff;
   logic [lsod_pkg::RANGE_W-1:0] s1_range_ff;
   logic                         s1_last_ff;
   logic [lsod_pkg::IDX_W-1:0]   sample_idx_ff;
   logic [lsod_pkg::IDX_W-1:0]   sample_idx_in;
   logic                         s1_fire;
   logic                         out_free;
   logic                         req_take;

   lsod_pkg::lsod_samp_type      samp;
   logic [lsod_pkg::IDX_W-1:0]   sec_first [lsod_pkg::NUM_SECTORS];
   logic [lsod_pkg::RANGE_W-1:0] sec_min [lsod_pkg::NUM_SECTORS];
   logic [lsod_pkg::NUM_SECTORS-1:0] mask;
   logic [lsod_pkg::ACTION_W-1:0] action;

   // result stage
   logic                          out_valid_ff;
   logic [lsod_pkg::ACTION_W-1:0] action_ff;
   logic [lsod_pkg::NUM_SECTORS-1:0] mask_ff;
   logic [lsod_pkg::RANGE_W-1:0]  min_ff [lsod_pkg::NUM_SECTORS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= 16'd800;
         end_ff[0]    <= 10'd33;
         end_ff[1]    <= 10'd66;
         end_ff[2]    <= 10'd100;
         end_ff[3]    <= 10'd133;
         end_ff[4]    <= 10'd166;
         end_ff[5]    <= 10'd199;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lsod_pkg::CSR_THRESHOLD:       threshold_ff <= csr_wdata;
            lsod_pkg::CSR_REAR_RIGHT_END:  end_ff[0] <= csr_wdata[lsod_pkg::END_W-1:0];
            lsod_pkg::CSR_RIGHT_END:       end_ff[1] <= csr_wdata[lsod_pkg::END_W-1:0];
            lsod_pkg::CSR_FRONT_RIGHT_END: end_ff[2] <= csr_wdata[lsod_pkg::END_W-1:0];
            lsod_pkg::CSR_FRONT_LEFT_END:  end_ff[3] <= csr_wdata[lsod_pkg::END_W-1:0];
            lsod_pkg::CSR_LEFT_END:        end_ff[4] <= csr_wdata[lsod_pkg::END_W-1:0];
            lsod_pkg::CSR_REAR_LEFT_END:   end_ff[5] <= csr_wdata[lsod_pkg::END_W-1:0];
            default: ;
         endcase
      end
   end

   // a non-last beat never needs the result register
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take || s1_fire) begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_range_ff <= req_range_mm;
         s1_last_ff  <= req_last_sample;
      end
   end

   always_comb begin
      sample_idx_in = sample_idx_ff;
      if (s1_last_ff) begin
         sample_idx_in = '0;
      end else if (sample_idx_ff < lsod_pkg::IDX_W'(lsod_pkg::MAX_SAMPLES)) begin
         sample_idx_in = sample_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_idx_ff <= '0;
      end else if (s1_fire) begin
         sample_idx_ff <= sample_idx_in;
      end
   end

   assign samp.fire     = s1_fire;
   assign samp.last     = s1_last_ff;
   assign samp.index    = sample_idx_ff;
   assign samp.range_mm = s1_range_ff;

   genvar k;
   generate
      for (k = 0; k < lsod_pkg::NUM_SECTORS; k++) begin : g_sector
         if (k == 0) begin : g_first
            assign sec_first[k] = '0;
         end else begin : g_next
            assign sec_first[k] = lsod_pkg::IDX_W'(end_ff[k-1]) + 1'b1;
         end
         lsod_sector u_sector (
            .clock     (clock),
            .reset     (reset),
            .samp      (samp),
            .first_idx (sec_first[k]),
            .end_idx   (end_ff[k]),
            .threshold (threshold_ff),
            .min_out   (sec_min[k]),
            .detect    (mask[k])
         );
      end
   endgenerate

   always_comb begin
      priority if (mask[lsod_pkg::SEC_FRONT_LEFT] && mask[lsod_pkg::SEC_FRONT_RIGHT]) begin
         action = lsod_pkg::ACT_BOTH_FRONT;
      end else if (mask[lsod_pkg::SEC_FRONT_LEFT]) begin
         action = lsod_pkg::ACT_TURN_RIGHT;
      end else if (mask[lsod_pkg::SEC_FRONT_RIGHT]) begin
         action = lsod_pkg::ACT_TURN_LEFT;
      end else if (mask[lsod_pkg::SEC_LEFT]) begin
         action = lsod_pkg::ACT_VEER_RIGHT;
      end else if (mask[lsod_pkg::SEC_RIGHT]) begin
         action = lsod_pkg::ACT_VEER_LEFT;
      end else if (mask[lsod_pkg::SEC_REAR_RIGHT]) begin
         action = lsod_pkg::ACT_REAR_RIGHT;
      end else if (mask[lsod_pkg::SEC_REAR_LEFT]) begin
         action = lsod_pkg::ACT_REAR_LEFT;
      end else begin
         action = lsod_pkg::ACT_FORWARD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_fire && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         action_ff <= action;
         mask_ff   <= mask;
         min_ff    <= sec_min;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_action          = action_ff;
   assign rsp_detect_mask     = mask_ff;
   assign rsp_min_rear_right  = min_ff[lsod_pkg::SEC_REAR_RIGHT];
   assign rsp_min_right       = min_ff[lsod_pkg::SEC_RIGHT];
   assign rsp_min_front_right = min_ff[lsod_pkg::SEC_FRONT_RIGHT];
   assign rsp_min_front_left  = min_ff[lsod_pkg::SEC_FRONT_LEFT];
   assign rsp_min_left        = min_ff[lsod_pkg::SEC_LEFT];
   assign rsp_min_rear_left   = min_ff[lsod_pkg::SEC_REAR_LEFT];

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      sample_idx_ff <= lsod_pkg::IDX_W'(lsod_pkg::MAX_SAMPLES))
      else $error("sample index beyond saturation");

   a_scan_clear: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> (sample_idx_ff == '0))
      else $error("sample index not cleared after last sample");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(s1_fire && s1_last_ff))
      else $error("result without a last sample");

   a_forward: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_detect_mask == '0) == (rsp_action == lsod_pkg::ACT_FORWARD)))
      else $error("action disagrees with detect mask");

endmodule
`default_nettype wire

// File: rtl/lsod_sector.sv
// One scan sector: running minimum, keep test and threshold compare.
`default_nettype none
module lsod_sector (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lsod_pkg::lsod_samp_type      samp,
   input  wire logic [lsod_pkg::IDX_W-1:0]   first_idx,
   input  wire logic [lsod_pkg::END_W-1:0]   end_idx,
   input  wire logic [lsod_pkg::RANGE_W-1:0] threshold,
   output logic      [lsod_pkg::RANGE_W-1:0] min_out,
   output logic                              detect
);

   logic [lsod_pkg::RANGE_W-1:0] min_ff;
   logic [lsod_pkg::RANGE_W-1:0] min_in;
   logic [lsod_pkg::IDX_W-1:0]   end_wide;
   logic                         in_sector;
   logic                         kept;

   assign end_wide  = lsod_pkg::IDX_W'(end_idx);
   assign in_sector = (samp.index < lsod_pkg::IDX_W'(lsod_pkg::MAX_SAMPLES)) &&
                      (samp.index >= first_idx) && (samp.index <= end_wide);
   assign min_in    = (in_sector && (samp.range_mm < min_ff)) ? samp.range_mm : min_ff;

   // only sectors whose end the scan reached count
   assign kept    = (end_wide < lsod_pkg::IDX_W'(lsod_pkg::MAX_SAMPLES)) &&
                    (end_wide <= samp.index);
   assign min_out = kept ? min_in : lsod_pkg::NO_RETURN;
   assign detect  = min_out < threshold;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= lsod_pkg::NO_RETURN;
      end else if (samp.fire) begin
         min_ff <= samp.last ? lsod_pkg::NO_RETURN : min_in;
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/steering_predictor_pkg.sv
// Expected-result predictor and checker for the lidar sector obstacle detector.
package steering_predictor_pkg;
   import lsod_pkg::*;

   typedef struct packed {
      logic [ACTION_W-1:0]                   action;
      logic [NUM_SECTORS-1:0]                mask;
      logic [NUM_SECTORS-1:0][RANGE_W-1:0]   minimum;
   } steer_verdict_type;

   class steering_predictor;
      logic [RANGE_W-1:0] threshold;
      logic [END_W-1:0]   sector_end [NUM_SECTORS];
      logic [IDX_W-1:0]   sample_index;
      logic [RANGE_W-1:0] running_min [NUM_SECTORS];
      steer_verdict_type  due_verdicts [$];
      int                 fails;

      function new();
         threshold  = 16'd800;
         sector_end = '{10'd33, 10'd66, 10'd100, 10'd133, 10'd166, 10'd199};
         fails      = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         sample_index = '0;
         for (int k = 0; k < NUM_SECTORS; k++) running_min[k] = NO_RETURN;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] index, logic [RANGE_W-1:0] value);
         if (index == CSR_THRESHOLD) begin
            threshold = value;
         end else if (index <= CSR_REAR_LEFT_END) begin
            sector_end[index - CSR_REAR_RIGHT_END] = value[END_W-1:0];
         end
      endfunction

      // one accepted sample beat; a last sample queues the steering verdict
      function void note_sample(logic [RANGE_W-1:0] value, logic is_last);
         logic [IDX_W-1:0]  idx;
         int                lo;
         steer_verdict_type v;
         idx = sample_index;
         lo  = 0;
         if (idx < MAX_SAMPLES) begin
            for (int k = 0; k < NUM_SECTORS; k++) begin
               if (int'(idx) >= lo && idx <= sector_end[k] && value < running_min[k])
                  running_min[k] = value;
               lo = int'(sector_end[k]) + 1;
            end
            sample_index = idx + 1'b1;
         end
         if (!is_last) return;
         v.mask = '0;
         for (int k = 0; k < NUM_SECTORS; k++) begin
            // a sector only counts once the scan has reached its end index
            v.minimum[k] = (sector_end[k] <= idx) ? running_min[k] : NO_RETURN;
            v.mask[k]    = v.minimum[k] < threshold;
         end
         if (v.mask[SEC_FRONT_LEFT] && v.mask[SEC_FRONT_RIGHT]) v.action = ACT_BOTH_FRONT;
         else if (v.mask[SEC_FRONT_LEFT])                         v.action = ACT_TURN_RIGHT;
         else if (v.mask[SEC_FRONT_RIGHT])                        v.action = ACT_TURN_LEFT;
         else if (v.mask[SEC_LEFT])                               v.action = ACT_VEER_RIGHT;
         else if (v.mask[SEC_RIGHT])                              v.action = ACT_VEER_LEFT;
         else if (v.mask[SEC_REAR_RIGHT])                         v.action = ACT_REAR_RIGHT;
         else if (v.mask[SEC_REAR_LEFT])                          v.action = ACT_REAR_LEFT;
         else                                                     v.action = ACT_FORWARD;
         due_verdicts.push_back(v);
         clear_scan();
      endfunction

      function void field_check(string what, int unsigned want, int unsigned got, time now);
         if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", now, what, want, got);
            fails++;
         end
      endfunction

      function void check_verdict(steer_verdict_type got, time now);
         steer_verdict_type want;
         if (due_verdicts.size() == 0) begin
            $display("%0t ns: result beat with none expected, expected nothing, actual action %0d",
                     now, got.action);
            fails++;
         end else begin
            want = due_verdicts.pop_front();
            field_check("action", want.action, got.action, now);
            field_check("detect_mask", want.mask, got.mask, now);
            for (int k = 0; k < NUM_SECTORS; k++)
               field_check($sformatf("minimum of sector %0d", k), want.minimum[k],
                           got.minimum[k], now);
         end
      endfunction
   endclass

endpackage

// File: tb/sv/lidar_sector_obstacle_detect_test.sv
// Testbench top for the lidar sector obstacle detector: directed and random scans, checked per beat.
module lidar_sector_obstacle_detect_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lsod_pkg::*;
   import steering_predictor_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [RANGE_W-1:0]     req_range_mm = '0;
   logic                   req_last_sample = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ACTION_W-1:0]    rsp_action;
   logic [NUM_SECTORS-1:0] rsp_detect_mask;
   logic [RANGE_W-1:0]     rsp_min_rear_right, rsp_min_right, rsp_min_front_right;
   logic [RANGE_W-1:0]     rsp_min_front_left, rsp_min_left, rsp_min_rear_left;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [RANGE_W-1:0]     csr_wdata = '0;

   steering_predictor      book;
   logic [RANGE_W-1:0]     plan_threshold;
   logic [END_W-1:0]       plan_end [NUM_SECTORS];
   int                     idle_pct = 0;
   int                     rsp_hold = 0;
   int                     cycle_count = 0;

   lidar_sector_obstacle_detect DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_range_mm        (req_range_mm),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_detect_mask     (rsp_detect_mask),
      .rsp_min_rear_right  (rsp_min_rear_right),
      .rsp_min_right       (rsp_min_right),
      .rsp_min_front_right (rsp_min_front_right),
      .rsp_min_front_left  (rsp_min_front_left),
      .rsp_min_left        (rsp_min_left),
      .rsp_min_rear_left   (rsp_min_rear_left),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side: check each taken beat, then decide the stall for the next cycle
   always @(posedge clock) begin
      steer_verdict_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.action                   = rsp_action;
         got.mask                     = rsp_detect_mask;
         got.minimum[SEC_REAR_RIGHT]  = rsp_min_rear_right;
         got.minimum[SEC_RIGHT]       = rsp_min_right;
         got.minimum[SEC_FRONT_RIGHT] = rsp_min_front_right;
         got.minimum[SEC_FRONT_LEFT]  = rsp_min_front_left;
         got.minimum[SEC_LEFT]        = rsp_min_left;
         got.minimum[SEC_REAR_LEFT]   = rsp_min_rear_left;
         book.check_verdict(got, $time);
      end
      if (idle_pct == 0)
         rsp_hold = 0;
      else if (rsp_hold > 0)
         rsp_hold = rsp_hold - 1;
      else if ($urandom_range(0, 99) < idle_pct)
         rsp_hold = $urandom_range(1, 13);
      rsp_stall <= (rsp_hold > 0);
   end

   task automatic send_sample(input logic [RANGE_W-1:0] value, input logic is_last);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_range_mm    <= value;
      req_last_sample <= is_last;
      do @(posedge clock); while (req_stall);
      book.note_sample(value, is_last);
   endtask

   // drain all pending verdicts, then give the pipeline a few spare cycles
   task automatic settle();
      req_valid <= 1'b0;
      while (book.due_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_registers();
      logic [CSR_IDX_W-1:0] idx;
      logic [RANGE_W-1:0]   val;
      for (int k = 0; k <= NUM_SECTORS; k++) begin
         if (k == 0) begin
            idx = CSR_THRESHOLD;
            val = plan_threshold;
         end else begin
            idx = CSR_REAR_RIGHT_END + CSR_IDX_W'(k - 1);
            val = RANGE_W'(plan_end[k-1]);
         end
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         do @(posedge clock); while (!csr_ready);
         book.set_reg(idx, val);
      end
      csr_valid <= 1'b0;
   endtask

   // danger marks sectors that get some samples below the threshold
   task automatic random_scan(input int length, input logic [NUM_SECTORS-1:0] danger);
      int                 lo, sec, thr;
      logic [RANGE_W-1:0] v;
      thr = int'(plan_threshold);
      for (int i = 0; i < length; i++) begin
         sec = -1;
         lo  = 0;
         for (int k = 0; k < NUM_SECTORS; k++) begin
            if (sec < 0 && i >= lo && i <= int'(plan_end[k])) sec = k;
            lo = int'(plan_end[k]) + 1;
         end
         if (sec >= 0 && danger[sec] && thr > 0 && $urandom_range(0, 1) == 0) begin
            v = RANGE_W'($urandom_range(0, thr - 1));
         end else begin
            case ($urandom_range(0, 7))
               0:       v = NO_RETURN;
               1:       v = RANGE_W'($urandom());
               default: v = RANGE_W'($urandom_range(thr, 65535));
            endcase
         end
         send_sample(v, i == length - 1);
      end
   endtask

   initial begin
      int                     sent, span, base, length;
      logic [NUM_SECTORS-1:0] danger;
      book = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: a single-sample scan keeps no sector
      send_sample(16'd0, 1'b1);
      settle();

      // one sample per sector, highest threshold
      plan_threshold = '1;
      for (int k = 0; k < NUM_SECTORS; k++) plan_end[k] = END_W'(k);
      program_registers();
      for (int i = 0; i < 6; i++) send_sample(16'd0, i == 5);
      for (int i = 0; i < 6; i++) send_sample(NO_RETURN, i == 5);
      for (int i = 0; i < 6; i++) send_sample((i == 0) ? 16'hFFFE : NO_RETURN, i == 5);
      settle();
      // zero threshold: nothing can be below it
      plan_threshold = '0;
      program_registers();
      for (int i = 0; i < 6; i++) send_sample(16'd0, i == 5);
      settle();

      // overlong scan, last sector ending at the top index
      idle_pct       = 10;
      plan_threshold = RANGE_W'($urandom_range(1, 3000));
      plan_end       = '{10'd100, 10'd300, 10'd500, 10'd700, 10'd900, 10'd1023};
      program_registers();
      random_scan(MAX_SAMPLES + int'($urandom_range(1, 40)),
                  NUM_SECTORS'($urandom_range(0, 63)));
      settle();

      sent = 0;
      while (sent < 500) begin
         case ($urandom_range(0, 5))
            0:       plan_threshold = '0;
            1:       plan_threshold = '1;
            2:       plan_threshold = RANGE_W'($urandom());
            default: plan_threshold = RANGE_W'($urandom_range(1, 3000));
         endcase
         base = $urandom_range(0, 4);
         for (int k = 0; k < NUM_SECTORS; k++) begin
            base        = base + int'($urandom_range(0, 6));
            plan_end[k] = END_W'(base);
            // occasional out-of-order or unreachable end
            case ($urandom_range(0, 11))
               0: plan_end[k] = END_W'($urandom_range(0, 40));
               1: plan_end[k] = 10'd1023;
               default: ;
            endcase
         end
         span = 0;
         for (int k = 0; k < NUM_SECTORS; k++)
            if (plan_end[k] < 64 && int'(plan_end[k]) + 1 > span) span = int'(plan_end[k]) + 1;
         if (span == 0) span = 8;
         program_registers();
         if (sent >= 350) begin
            idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 5;
               default: idle_pct = 25;
            endcase
         end
         repeat ($urandom_range(3, 10)) begin
            if ($urandom_range(0, 3) != 0) length = span + int'($urandom_range(0, 3));
            else                            length = int'($urandom_range(1, span));
            danger = NUM_SECTORS'($urandom_range(0, 63) & $urandom_range(0, 63));
            random_scan(length, danger);
            sent = sent + length;
         end
         settle();
      end

      if (book.fails == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
